// ===== design/segmented_array_index_translate_macros.svh =====
// Assertion macros for the segmented array index translator.
// Included by modules that carry concurrent checks.
`ifndef SEGMENTED_ARRAY_INDEX_TRANSLATE_MACROS_SVH
`define SEGMENTED_ARRAY_INDEX_TRANSLATE_MACROS_SVH
`ifndef ASSERT_OFF
`define SAIT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAIT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAIT_ASSERT(label, clk, rst, prop, msg)
`define SAIT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== design/sait_pkg.sv =====
// Shared types and constants of the segmented array index translator.
// No dependencies.
package sait_pkg;
   localparam int IdxW   = 32;
   localparam int AddrW  = 64;
   localparam int ItemsW = 20;
   localparam int SlotsW = 10;
   localparam int SizeW  = 16;
   localparam int NodeW  = 24;
   localparam int BlkW   = 31;
   localparam int QueueDepth = 4;

   localparam logic [1:0] RegionBase   = 2'd0;
   localparam logic [1:0] RegionInline = 2'd1;
   localparam logic [1:0] RegionSlot   = 2'd2;

   localparam logic [2:0] RegBaseLength = 3'd0;
   localparam logic [2:0] RegBaseAddr   = 3'd1;
   localparam logic [2:0] RegInline     = 3'd2;
   localparam logic [2:0] RegSlotItems  = 3'd3;
   localparam logic [2:0] RegSlots      = 3'd4;
   localparam logic [2:0] RegItemSize   = 3'd5;
   localparam logic [2:0] RegNodeCount  = 3'd6;

   // configuration registers as one group
   typedef struct packed {
      logic [IdxW-1:0]   base_length;
      logic [AddrW-1:0]  base_address;
      logic [ItemsW-1:0] node_inline_items;
      logic [ItemsW-1:0] chunk_items;
      logic [SlotsW-1:0] slots_per_node;
      logic [SizeW-1:0]  item_size;
      logic [NodeW-1:0]  nodes_alloc;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic            is_base;
      logic            empty_blk;
      logic [IdxW-1:0] value;   // index in base region, else index minus base length
   } job_type;
endpackage

// ===== design/segmented_array_index_translate.sv =====
// Segmented array index translator: top level.
// Depends on sait_pkg, sait_front, sait_back.
//
// Use: pulse start with req_element_index while busy is low; the request is
// taken at that edge. Configure through the csr_ APB-style port while idle;
// registers sit at byte address 8*i, reads return the value.
// Each request gives exactly one result, shown for one cycle with rsp_valid.
// Path from the accepting edge to rsp_valid: the queue, two 32-stage
// pipelined dividers (node divide, then slot divide), a classification
// stage, a multiply stage and the output register.
// Throughput: one request per cycle; the back end takes a job every cycle
// one is queued, so busy never rises.
// Reset: registers return to their reset values and all pipelines empty.
// The receiver cannot stall; results are never held.
module segmented_array_index_translate #(
   parameter int QueueDepth = sait_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_element_index,
   output logic        rsp_valid,
   output logic [1:0]  rsp_region,
   output logic [23:0] rsp_node_number,
   output logic [9:0]  rsp_slot_number,
   output logic [31:0] rsp_item_offset,
   output logic [63:0] rsp_byte_address,
   output logic        rsp_out_of_range
);
   sait_pkg::cfg_type cfg;
   sait_pkg::job_type job;
   logic job_valid, job_take;

   assign pready = 1'b1;

   sait_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .csr_psel(psel), .csr_penable(penable), .csr_pwrite(pwrite),
      .csr_paddr(paddr), .csr_pwdata(pwdata), .csr_prdata(prdata),
      .start, .req_element_index, .busy, .cfg, .job_valid, .job, .job_take);

   sait_back u_back (
      .clock, .reset, .cfg, .job_valid, .job, .job_take,
      .rsp_valid, .rsp_region, .rsp_node_number, .rsp_slot_number,
      .rsp_item_offset, .rsp_byte_address, .rsp_out_of_range);
endmodule

// ===== design/sait_front.sv =====
// Front end: register file, request classification and the job queue.
// Depends on sait_pkg.
module sait_front #(
   parameter int Depth = sait_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [5:0]             csr_paddr,
   input  logic [63:0]            csr_pwdata,
   output logic [63:0]            csr_prdata,
   input  logic                   start,
   input  logic [31:0]            req_element_index,
   output logic                   busy,
   output sait_pkg::cfg_type      cfg,
   output logic                   job_valid,
   output sait_pkg::job_type      job,
   input  logic                   job_take
);
   localparam int PtrW = $clog2(Depth);
   sait_pkg::cfg_type cfg_ff;
   sait_pkg::job_type q_ff [Depth];
   logic [PtrW-1:0] wr_ff, rd_ff;
   logic [PtrW:0]   cnt_ff;
   logic [2:0]      reg_sel;
   logic            push;
   sait_pkg::job_type job_in;
   logic [sait_pkg::BlkW-1:0] blk;

   assign reg_sel = csr_paddr[5:3];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{default: '0, node_inline_items: 20'd1, chunk_items: 20'd1,
                     item_size: 16'd1};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_sel)
            sait_pkg::RegBaseLength: cfg_ff.base_length <= csr_pwdata[31:0];
            sait_pkg::RegBaseAddr:   cfg_ff.base_address <= csr_pwdata;
            sait_pkg::RegInline:     cfg_ff.node_inline_items <= csr_pwdata[19:0];
            sait_pkg::RegSlotItems:  cfg_ff.chunk_items <= csr_pwdata[19:0];
            sait_pkg::RegSlots:      cfg_ff.slots_per_node <= csr_pwdata[9:0];
            sait_pkg::RegItemSize:   cfg_ff.item_size <= csr_pwdata[15:0];
            sait_pkg::RegNodeCount:  cfg_ff.nodes_alloc <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_sel)
         sait_pkg::RegBaseLength: csr_prdata = {32'd0, cfg_ff.base_length};
         sait_pkg::RegBaseAddr:   csr_prdata = cfg_ff.base_address;
         sait_pkg::RegInline:     csr_prdata = {44'd0, cfg_ff.node_inline_items};
         sait_pkg::RegSlotItems:  csr_prdata = {44'd0, cfg_ff.chunk_items};
         sait_pkg::RegSlots:      csr_prdata = {54'd0, cfg_ff.slots_per_node};
         sait_pkg::RegItemSize:   csr_prdata = {48'd0, cfg_ff.item_size};
         sait_pkg::RegNodeCount:  csr_prdata = {40'd0, cfg_ff.nodes_alloc};
         default:                 csr_prdata = '0;
      endcase
   end
   assign cfg = cfg_ff;

   // classify: base region, empty block, or node request
   assign blk = sait_pkg::BlkW'(cfg_ff.node_inline_items)
              + sait_pkg::BlkW'(cfg_ff.slots_per_node * cfg_ff.chunk_items);
   always_comb begin
      job_in.is_base   = req_element_index < cfg_ff.base_length;
      job_in.empty_blk = (blk == '0);
      job_in.value     = job_in.is_base ? req_element_index
                                        : req_element_index - cfg_ff.base_length;
   end

   // job queue
   assign busy      = (cnt_ff == (PtrW+1)'(Depth));
   assign push      = start && !busy;
   assign job_valid = (cnt_ff != '0);
   assign job       = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= job_in;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= PtrW'((wr_ff + 1'b1) % Depth);
         if (job_take) rd_ff <= PtrW'((rd_ff + 1'b1) % Depth);
         cnt_ff <= cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(job_take);
      end
   end
endmodule

// ===== design/sait_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; carries a side payload alongside.
module sait_div #(
   parameter int NumW = 32,
   parameter int DenW = 31,
   parameter int TagW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [NumW-1:0] in_num,
   input  logic [DenW-1:0] in_den,
   input  logic [TagW-1:0] in_tag,
   output logic            out_valid,
   output logic [NumW-1:0] out_quo,
   output logic [DenW-1:0] out_rem,
   output logic [TagW-1:0] out_tag
);
   logic            v_ff   [NumW+1];
   logic [NumW-1:0] n_ff   [NumW+1];
   logic [DenW-1:0] r_ff   [NumW+1];
   logic [DenW-1:0] d_ff   [NumW+1];
   logic [TagW-1:0] t_ff   [NumW+1];

   always_comb begin
      v_ff[0] = in_valid; n_ff[0] = in_num; r_ff[0] = '0;
      d_ff[0] = in_den;   t_ff[0] = in_tag;
   end

   // each stage shifts one numerator bit into the partial remainder
   for (genvar s = 0; s < NumW; s++) begin : g_stage
      logic [DenW:0] trial;
      logic          fits;
      logic            v_in_ff;
      logic [NumW-1:0] n_in_ff;
      logic [DenW-1:0] r_in_ff, d_in_ff;
      logic [TagW-1:0] t_in_ff;
      assign trial = {r_ff[s], n_ff[s][NumW-1]};
      assign fits  = trial >= {1'b0, d_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) v_in_ff <= 1'b0;
         else       v_in_ff <= v_ff[s];
      end
      always_ff @(posedge clock) begin
         n_in_ff <= {n_ff[s][NumW-2:0], fits};
         r_in_ff <= fits ? DenW'(trial - {1'b0, d_ff[s]}) : DenW'(trial);
         d_in_ff <= d_ff[s];
         t_in_ff <= t_ff[s];
      end
      always_comb begin
         v_ff[s+1] = v_in_ff; n_ff[s+1] = n_in_ff; r_ff[s+1] = r_in_ff;
         d_ff[s+1] = d_in_ff; t_ff[s+1] = t_in_ff;
      end
   end

   assign out_valid = v_ff[NumW];
   assign out_quo   = n_ff[NumW];
   assign out_rem   = r_ff[NumW];
   assign out_tag   = t_ff[NumW];
endmodule

// ===== design/sait_back.sv =====
// Back end: node divide, slot divide, byte offset and result register.
// Depends on sait_pkg, sait_div and the assertion macro header.
`include "segmented_array_index_translate_macros.svh"
module sait_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sait_pkg::cfg_type    cfg,
   input  logic                 job_valid,
   input  sait_pkg::job_type    job,
   output logic                 job_take,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_region,
   output logic [23:0]          rsp_node_number,
   output logic [9:0]           rsp_slot_number,
   output logic [31:0]          rsp_item_offset,
   output logic [63:0]          rsp_byte_address,
   output logic                 rsp_out_of_range
);
   localparam int BW = sait_pkg::BlkW;
   localparam int TW1 = 2;
   localparam int TW2 = 3 + sait_pkg::NodeW + 1;

   logic [BW-1:0] blk;
   logic          d1_v;
   logic [31:0]   d1_q;
   logic [BW-1:0] d1_r;
   logic [TW1-1:0] d1_t;
   logic          st_v_ff, st_base_ff, st_empty_ff, st_slot_ff, st_oor_ff;
   logic [31:0]   st_off_ff;
   logic [23:0]   st_node_ff;
   logic [TW2-1:0] s_tag;
   logic [BW-1:0] s_den;
   logic          d2_v;
   logic [31:0]   d2_q;
   logic [BW-1:0] d2_r;
   logic [TW2-1:0] d2_t;
   logic [1:0]    m_region_in;
   logic [9:0]    m_slot_in;
   logic [31:0]   m_off_in;
   logic          m_v_ff, m_base_ff, m_oor_ff;
   logic [1:0]    m_region_ff;
   logic [23:0]   m_node_ff;
   logic [9:0]    m_slot_ff;
   logic [31:0]   m_off_ff;
   logic [47:0]   m_prod_ff;

   assign job_take = job_valid;
   assign blk = BW'(cfg.node_inline_items) + BW'(cfg.slots_per_node * cfg.chunk_items);

   // node divide: value / block (base and empty jobs ride along)
   sait_div #(.NumW(32), .DenW(BW), .TagW(TW1)) u_node_div (
      .clock, .reset, .in_valid(job_valid), .in_num(job.value),
      .in_den(job.is_base ? BW'(1) : (job.empty_blk ? BW'(1) : blk)),
      .in_tag({job.is_base, job.empty_blk}),
      .out_valid(d1_v), .out_quo(d1_q), .out_rem(d1_r), .out_tag(d1_t));

   // classify remainder: inline area or slot area
   always_ff @(posedge clock) begin
      if (reset) st_v_ff <= 1'b0;
      else       st_v_ff <= d1_v;
   end
   always_ff @(posedge clock) begin
      st_base_ff  <= d1_t[1];
      st_empty_ff <= d1_t[0];
      st_slot_ff  <= d1_r >= BW'(cfg.node_inline_items);
      st_off_ff   <= d1_t[1] ? d1_q
                   : (d1_r >= BW'(cfg.node_inline_items)
                      ? 32'(d1_r - BW'(cfg.node_inline_items)) : 32'(d1_r));
      st_node_ff  <= d1_q[23:0];
      st_oor_ff   <= d1_t[0] || (d1_q >= 32'(cfg.nodes_alloc));
   end

   // slot divide: offset / chunk size in the slot region; other requests
   // divide by one so the offset comes out as the quotient
   assign s_den = (st_slot_ff && !st_base_ff && !st_empty_ff) ? BW'(cfg.chunk_items)
                                                              : BW'(1);
   assign s_tag = {st_base_ff, st_empty_ff, st_slot_ff, st_node_ff, st_oor_ff};
   sait_div #(.NumW(32), .DenW(BW), .TagW(TW2)) u_slot_div (
      .clock, .reset, .in_valid(st_v_ff), .in_num(st_off_ff),
      .in_den(s_den),
      .in_tag(s_tag),
      .out_valid(d2_v), .out_quo(d2_q), .out_rem(d2_r), .out_tag(d2_t));

   // field assembly
   always_comb begin
      m_region_in = sait_pkg::RegionInline;
      m_slot_in   = 10'd0;
      m_off_in    = d2_q;
      if (d2_t[TW2-1]) begin
         m_region_in = sait_pkg::RegionBase;
      end else if (d2_t[TW2-2]) begin
         // empty block: region reads inline; everything else but the flag is zero
         m_off_in    = 32'd0;
      end else if (d2_t[TW2-3]) begin
         m_region_in = sait_pkg::RegionSlot;
         m_slot_in   = d2_q[9:0];
         m_off_in    = 32'(d2_r);
      end
   end

   // field register and multiply
   always_ff @(posedge clock) begin
      if (reset) m_v_ff <= 1'b0;
      else       m_v_ff <= d2_v;
   end
   always_ff @(posedge clock) begin
      m_base_ff   <= d2_t[TW2-1];
      m_oor_ff    <= d2_t[TW2-1] ? 1'b0 : d2_t[0];
      m_node_ff   <= (d2_t[TW2-1] || d2_t[TW2-2]) ? 24'd0 : d2_t[24:1];
      m_region_ff <= m_region_in;
      m_slot_ff   <= m_slot_in;
      m_off_ff    <= m_off_in;
      m_prod_ff   <= 48'(m_off_in) * 48'(cfg.item_size);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= m_v_ff;
   end
   always_ff @(posedge clock) begin
      rsp_region       <= m_region_ff;
      rsp_node_number  <= m_node_ff;
      rsp_slot_number  <= m_slot_ff;
      rsp_item_offset  <= m_off_ff;
      rsp_out_of_range <= m_oor_ff;
      rsp_byte_address <= m_base_ff ? cfg.base_address + 64'(m_prod_ff) : 64'(m_prod_ff);
   end

   `SAIT_ASSERT(a_base_clean, clock, reset, rsp_valid && rsp_region == sait_pkg::RegionBase |-> !rsp_out_of_range && rsp_node_number == 24'd0, "base result flagged")
   `SAIT_ASSERT(a_region_legal, clock, reset, rsp_valid |-> rsp_region <= sait_pkg::RegionSlot, "bad region")
   `SAIT_ASSERT(a_slot_zero, clock, reset, rsp_valid && rsp_region != sait_pkg::RegionSlot |-> rsp_slot_number == 10'd0, "slot set outside slot region")
endmodule
